>>> src/ordered_wait_list_defines.svh
// Assertion macros shared by the ordered wait list checkers.
`ifndef ORDERED_WAIT_LIST_DEFINES_SVH
`define ORDERED_WAIT_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OWL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/owl_pkg.sv
// Types, codes and sizes shared by the ordered wait list modules.
package owl_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OCC_W    = 5;
  localparam int FID_W    = 16;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_WAKE_ONE = 2'd2,
    REQ_WAKE_ALL = 2'd3
  } owl_req_t;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_WOKEN     = 3'd4,
    STAT_EMPTY     = 3'd5
  } owl_status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } owl_state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [FID_W-1:0] entry_id;
  } owl_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [FID_W-1:0] woken_id;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } owl_out_t;

  // Broadcast controls seen by every cell of the chain
  typedef struct packed {
    logic                rm;
    logic                shift;
    logic                ins;
    logic [ID_WIDTH-1:0] key;
  } owl_cell_ctl_t;

endpackage

>>> src/owl_cell.sv
// One slot of the wait list chain: holds an id, compares, shifts toward the head.
module owl_cell (
  input  logic                          clk,
  input  owl_pkg::owl_cell_ctl_t        ctl,
  input  logic                          active,
  input  logic                          tail,
  input  logic [owl_pkg::ID_WIDTH-1:0]  nbr_id,
  input  logic                          seen_in,
  output logic [owl_pkg::ID_WIDTH-1:0]  id_q,
  output logic                          seen_out
);

  logic [owl_pkg::ID_WIDTH-1:0] id_r;
  logic [owl_pkg::ID_WIDTH-1:0] id_nxt;
  logic                         hit;

  // a match at this slot or nearer the head closes the gap here
  assign hit      = ctl.rm && active && (id_r == ctl.key);
  assign seen_out = seen_in | hit;

  always_comb begin
    if (ctl.ins && tail) begin
      id_nxt = ctl.key;
    end else if (ctl.shift || (ctl.rm && seen_out)) begin
      id_nxt = nbr_id;
    end else begin
      id_nxt = id_r;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_q = id_r;

endmodule

>>> src/ordered_wait_list.sv
// Ordered wait list: FIFO of waiter ids with remove-by-id, pop and drain-all.
//
// Input channel in_valid/in_stall/in_data carries one request per beat:
// insert, remove by id, wake one, wake all. Result channel
// out_valid/out_stall/out_data returns status, woken id, last and occupancy.
// Insert, remove and wake one update the chain of compare-and-shift cells
// and give one result beat, registered, in the cycle after accept. A new
// request is taken every cycle while the result register drains and no
// wake all runs. Wake all on a non-empty list enters a drain state, then
// moves one id per cycle out of the head cell while the result register
// drains; no request is accepted until the final beat (last set) is in
// the result register. A stalled result beat holds; in_stall rises while
// the result register is full and stalled. Reset (rst_n low, synchronous)
// empties the list and drops any pending result; slots are not cleared.
module ordered_wait_list (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  owl_pkg::owl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output owl_pkg::owl_out_t out_data
);

  localparam int DEPTH = owl_pkg::DEPTH;
  localparam int IDW   = owl_pkg::ID_WIDTH;
  localparam int CNT_W = owl_pkg::CNT_W;
  localparam int OCC_W = owl_pkg::OCC_W;
  localparam int FID_W = owl_pkg::FID_W;

  owl_pkg::owl_state_t    state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  owl_pkg::owl_out_t      out_data_r, out_data_nxt;
  owl_pkg::owl_cell_ctl_t ctl;

  logic [IDW-1:0]   ids [DEPTH];
  logic [DEPTH-1:0] seen;
  logic             found;
  logic             out_free;
  logic             acc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != owl_pkg::S_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;
  assign found    = seen[DEPTH-1];

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IDW-1:0] nbr;
    logic           sin;
    if (i == DEPTH - 1) begin : g_end
      assign nbr = ids[i];
    end else begin : g_mid
      assign nbr = ids[i+1];
    end
    if (i == 0) begin : g_head
      assign sin = 1'b0;
    end else begin : g_body
      assign sin = seen[i-1];
    end
    owl_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .active   (count_r > CNT_W'(i)),
      .tail     (count_r == CNT_W'(i)),
      .nbr_id   (nbr),
      .seen_in  (sin),
      .id_q     (ids[i]),
      .seen_out (seen[i])
    );
  end

  // Chain controls, kept apart from the match result they produce
  always_comb begin
    ctl.rm    = 1'b0;
    ctl.shift = 1'b0;
    ctl.ins   = 1'b0;
    ctl.key   = IDW'(in_data.entry_id);
    if (state_r == owl_pkg::S_BURST) begin
      ctl.shift = out_free;
    end else if (acc) begin
      case (owl_pkg::owl_req_t'(in_data.req_type))
        owl_pkg::REQ_INSERT: begin
          ctl.ins = (count_r < CNT_W'(DEPTH));
        end
        owl_pkg::REQ_REMOVE: begin
          ctl.rm = 1'b1;
        end
        owl_pkg::REQ_WAKE_ONE: begin
          ctl.shift = (count_r != '0);
        end
        default: begin
        end
      endcase
    end
  end

  // Request decode and result formation
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    if (state_r == owl_pkg::S_BURST) begin
      // drain one id per cycle from the head cell while the result register is free
      if (out_free) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.status    = owl_pkg::STAT_WOKEN;
        out_data_nxt.woken_id  = FID_W'(ids[0]);
        out_data_nxt.last      = (left_r == CNT_W'(1));
        out_data_nxt.occupancy = '0;
        left_nxt               = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1)) begin
          state_nxt = owl_pkg::S_IDLE;
        end
      end
    end else if (acc) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.woken_id = '0;
      out_data_nxt.last     = 1'b1;
      case (owl_pkg::owl_req_t'(in_data.req_type))
        owl_pkg::REQ_INSERT: begin
          if (count_r < CNT_W'(DEPTH)) begin
            count_nxt           = count_r + CNT_W'(1);
            out_data_nxt.status = owl_pkg::STAT_INSERTED;
          end else begin
            out_data_nxt.status = owl_pkg::STAT_FULL;
          end
        end
        owl_pkg::REQ_REMOVE: begin
          if (found) begin
            count_nxt           = count_r - CNT_W'(1);
            out_data_nxt.status = owl_pkg::STAT_REMOVED;
          end else begin
            out_data_nxt.status = owl_pkg::STAT_NOT_FOUND;
          end
        end
        owl_pkg::REQ_WAKE_ONE: begin
          if (count_r == '0) begin
            out_data_nxt.status = owl_pkg::STAT_EMPTY;
          end else begin
            count_nxt             = count_r - CNT_W'(1);
            out_data_nxt.status   = owl_pkg::STAT_WOKEN;
            out_data_nxt.woken_id = FID_W'(ids[0]);
          end
        end
        owl_pkg::REQ_WAKE_ALL: begin
          if (count_r == '0) begin
            out_data_nxt.status = owl_pkg::STAT_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            left_nxt      = count_r;
            count_nxt     = '0;
            state_nxt     = owl_pkg::S_BURST;
          end
        end
        default: begin
          out_data_nxt.status = owl_pkg::STAT_EMPTY;
        end
      endcase
      if (state_nxt == owl_pkg::S_IDLE) begin
        out_data_nxt.occupancy = OCC_W'(count_nxt);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= owl_pkg::S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/owl_checker.sv
// Port-level checks for the ordered wait list, bound to its top level.
`include "ordered_wait_list_defines.svh"

module owl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input owl_pkg::owl_out_t out_data
);

  logic [owl_pkg::OCC_W-1:0] cap;
  logic                      held;
  logic                      woken;
  logic                      mid;
  logic                      drained;
  logic                      refused;

  assign cap     = owl_pkg::OCC_W'(owl_pkg::DEPTH);
  assign held    = out_valid && out_stall;
  assign woken   = (out_data.status == owl_pkg::STAT_WOKEN);
  assign mid     = out_valid && !out_data.last;
  assign drained = woken && (out_data.occupancy == '0);
  assign refused = out_valid && (out_data.status == owl_pkg::STAT_FULL);

  // stalled result beat holds
  `OWL_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_data), "stalled beat changed")

  // occupancy never exceeds capacity
  `OWL_ASSERT_NOW(a_occ_range, out_valid, out_data.occupancy <= cap, "occupancy above capacity")

  // only a woken beat carries an id
  `OWL_ASSERT_NOW(a_id_zero, out_valid && !woken, out_data.woken_id == '0, "stray woken id")

  // a beat without last belongs to a drain: woken and list emptied
  `OWL_ASSERT_NOW(a_burst_beat, mid, drained, "bad mid-burst beat")

  // refusal only when the list is full
  `OWL_ASSERT_NOW(a_full_occ, refused, out_data.occupancy == cap, "refused below capacity")

endmodule

bind ordered_wait_list owl_checker u_owl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
